@@ hw/rtl/lgts_pkg.sv @@
`timescale 1ns / 1ps
package lgts_pkg;

  // Table geometry
  localparam int TOPICS     = 16;
  localparam int TOPIC_W    = 4;
  localparam int KCOUNT_W   = 5;
  localparam int DOC_W      = 8;
  localparam int WORD_W     = 10;
  localparam int TOKEN_W    = 12;
  localparam int RAND_W     = 31;
  localparam int DOC_AW     = DOC_W + TOPIC_W;
  localparam int WORD_AW    = WORD_W + TOPIC_W;
  localparam int DOC_DEPTH  = 1 << DOC_AW;
  localparam int WORD_DEPTH = 1 << WORD_AW;
  localparam int TOK_DEPTH  = 1 << TOKEN_W;

  // Counts
  localparam int COUNT_W = 13;
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  // Configuration
  localparam int CFG_W     = 24;
  localparam int CFG_IDX_W = 2;
  localparam int VOCAB_W   = 11;

  // Arithmetic widths
  localparam int QFRAC    = 16;
  localparam int OPND_W   = COUNT_W + QFRAC + 1;
  localparam int NUM_W    = 2 * OPND_W;
  localparam int VB_W     = VOCAB_W + CFG_W;
  localparam int DEN_W    = VB_W + 1;
  localparam int WEIGHT_W = 48;
  localparam int TOTAL_W  = WEIGHT_W + TOPIC_W;
  localparam int DIV_CNT_W = 6;
  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(NUM_W - 1);
  localparam logic [WEIGHT_W-1:0] WEIGHT_MAX = {WEIGHT_W{1'b1}};

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ALPHA = 2'd0,
    REG_BETA  = 2'd1,
    REG_TOPIC = 2'd2,
    REG_VOCAB = 2'd3
  } lgts_reg_t;

  // Datapath operations
  typedef enum logic [4:0] {
    OP_NONE,
    OP_CLEAR,
    OP_LOAD,
    OP_MOD_START,
    OP_MOD_STORE,
    OP_OLD,
    OP_DEC,
    OP_W_RD,
    OP_W_MUL,
    OP_DIV_START,
    OP_W_STORE,
    OP_THR1,
    OP_THR2,
    OP_SEARCH,
    OP_ADD_RD,
    OP_INC,
    OP_OUT
  } lgts_op_t;

  typedef struct packed {
    lgts_op_t op;
  } lgts_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic mode;
    logic div_done;
    logic last_topic;
    logic search_hit;
    logic out_busy;
  } lgts_status_t;

endpackage

@@ hw/rtl/lda_gibbs_topic_sampler.sv @@
`timescale 1ns / 1ps
// Mode 0 draws the topic as the random value modulo K on the shared divider.
// Mode 1 works through the K active topics on the bit-serial divider, one weight
// quotient per topic, then searches the cumulative weights for the topic.
// One token at a time; the next transfer is taken once the result is registered.
// Reset (rst_n, synchronous, low) starts a clearing pass of the count memories;
// no input is taken until it ends. Configuration writes are taken whenever rst_n is high.
module lda_gibbs_topic_sampler (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_mode,
  input  logic [lgts_pkg::TOKEN_W-1:0]   in_token_index,
  input  logic [lgts_pkg::DOC_W-1:0]     in_doc_id,
  input  logic [lgts_pkg::WORD_W-1:0]    in_word_id,
  input  logic [lgts_pkg::RAND_W-1:0]    in_rand_value,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [lgts_pkg::TOPIC_W-1:0]   out_topic,
  output logic                           out_changed,
  input  logic                           cfg_we,
  input  logic [lgts_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lgts_pkg::CFG_W-1:0]     cfg_wdata
);
  import lgts_pkg::*;

  lgts_cmd_t    cmd;
  lgts_status_t st;

  lgts_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  lgts_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .st             (st),
    .in_mode        (in_mode),
    .in_token_index (in_token_index),
    .in_doc_id      (in_doc_id),
    .in_word_id     (in_word_id),
    .in_rand_value  (in_rand_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_topic      (out_topic),
    .out_changed    (out_changed),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

endmodule

@@ hw/rtl/lgts_div.sv @@
`timescale 1ns / 1ps
module lgts_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [lgts_pkg::NUM_W-1:0] num,
  input  logic [lgts_pkg::DEN_W-1:0] den,
  output logic                       done,
  output logic [lgts_pkg::NUM_W-1:0] quo,
  output logic [lgts_pkg::DEN_W-1:0] rem
);
  import lgts_pkg::*;

  logic                 busy_r;
  logic                 done_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [NUM_W-1:0]     quo_r;
  logic [DEN_W-1:0]     rem_r;
  logic [DEN_W-1:0]     den_r;
  logic [DEN_W:0]       trial;
  logic [DEN_W:0]       diff;
  logic                 ge;

  // one quotient bit per cycle, restoring
  assign trial = {rem_r, quo_r[NUM_W-1]};
  assign ge    = trial >= {1'b0, den_r};
  assign diff  = trial - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DIV_LAST) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (busy_r) begin
      quo_r <= {quo_r[NUM_W-2:0], ge};
      rem_r <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
    end
  end

  assign done = done_r;
  assign quo  = quo_r;
  assign rem  = rem_r;

endmodule

@@ hw/rtl/lgts_ctrl.sv @@
`timescale 1ns / 1ps
module lgts_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  lgts_pkg::lgts_status_t st,
  output lgts_pkg::lgts_cmd_t    cmd
);
  import lgts_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_SEL, S_MOD, S_MOD_WAIT, S_OLD, S_DEC, S_W_RD, S_W_MUL,
    S_W_DIV, S_W_WAIT, S_THR1, S_THR2, S_SEARCH, S_ADD_RD, S_ADD_WR
  } state_t;

  state_t state_r;
  logic   done_pend_r;

  assign in_ready = (state_r == S_IDLE) && !done_pend_r;

  // operation issued in each state
  always_comb begin
    cmd.op = OP_NONE;
    if (done_pend_r) begin
      cmd.op = st.out_busy ? OP_NONE : OP_OUT;
    end else begin
      case (state_r)
        S_CLEAR:    cmd.op = OP_CLEAR;
        S_IDLE:     cmd.op = in_valid ? OP_LOAD : OP_NONE;
        S_MOD:      cmd.op = OP_MOD_START;
        S_MOD_WAIT: cmd.op = st.div_done ? OP_MOD_STORE : OP_NONE;
        S_OLD:      cmd.op = OP_OLD;
        S_DEC:      cmd.op = OP_DEC;
        S_W_RD:     cmd.op = OP_W_RD;
        S_W_MUL:    cmd.op = OP_W_MUL;
        S_W_DIV:    cmd.op = OP_DIV_START;
        S_W_WAIT:   cmd.op = st.div_done ? OP_W_STORE : OP_NONE;
        S_THR1:     cmd.op = OP_THR1;
        S_THR2:     cmd.op = OP_THR2;
        S_SEARCH:   cmd.op = OP_SEARCH;
        S_ADD_RD:   cmd.op = OP_ADD_RD;
        S_ADD_WR:   cmd.op = OP_INC;
        default:    cmd.op = OP_NONE;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      done_pend_r <= 1'b0;
    end else if (done_pend_r) begin
      if (!st.out_busy) done_pend_r <= 1'b0;
    end else begin
      case (state_r)
        S_CLEAR:    if (st.clear_last) state_r <= S_IDLE;
        S_IDLE:     if (in_valid) state_r <= S_SEL;
        S_SEL:      state_r <= st.mode ? S_OLD : S_MOD;
        S_MOD:      state_r <= S_MOD_WAIT;
        S_MOD_WAIT: if (st.div_done) state_r <= S_ADD_RD;
        S_OLD:      state_r <= S_DEC;
        S_DEC:      state_r <= S_W_RD;
        S_W_RD:     state_r <= S_W_MUL;
        S_W_MUL:    state_r <= S_W_DIV;
        S_W_DIV:    state_r <= S_W_WAIT;
        S_W_WAIT: begin
          if (st.div_done) state_r <= st.last_topic ? S_THR1 : S_W_RD;
        end
        S_THR1:     state_r <= S_THR2;
        S_THR2:     state_r <= S_SEARCH;
        S_SEARCH:   if (st.search_hit) state_r <= S_ADD_RD;
        S_ADD_RD:   state_r <= S_ADD_WR;
        S_ADD_WR: begin
          state_r     <= S_IDLE;
          done_pend_r <= 1'b1;
        end
        default:    state_r <= S_IDLE;
      endcase
    end
  end

endmodule

@@ hw/rtl/lgts_dp.sv @@
`timescale 1ns / 1ps
module lgts_dp (
  input  logic                         clk,
  input  logic                         rst_n,
  input  lgts_pkg::lgts_cmd_t          cmd,
  output lgts_pkg::lgts_status_t       st,
  input  logic                         in_mode,
  input  logic [lgts_pkg::TOKEN_W-1:0] in_token_index,
  input  logic [lgts_pkg::DOC_W-1:0]   in_doc_id,
  input  logic [lgts_pkg::WORD_W-1:0]  in_word_id,
  input  logic [lgts_pkg::RAND_W-1:0]  in_rand_value,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [lgts_pkg::TOPIC_W-1:0] out_topic,
  output logic                         out_changed,
  input  logic                         cfg_we,
  input  logic [lgts_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lgts_pkg::CFG_W-1:0]   cfg_wdata
);
  import lgts_pkg::*;

  // configuration
  logic [CFG_W-1:0]    alpha_r, beta_r;
  logic [KCOUNT_W-1:0] topics_r;
  logic [VOCAB_W-1:0]  vocab_r;

  // token context
  logic                mode_r;
  logic [TOKEN_W-1:0]  tok_r;
  logic [DOC_W-1:0]    doc_r;
  logic [WORD_W-1:0]   word_r;
  logic [RAND_W-1:0]   rnd_r;
  logic [TOPIC_W-1:0]  km1_r;
  logic [VB_W-1:0]     vb_r;
  logic [TOPIC_W-1:0]  z_old_r, z_new_r, z_cnt_r;
  logic                changed_r;

  // weights and sums
  logic [NUM_W-1:0]    num_r;
  logic [DEN_W-1:0]    den_r;
  logic [WEIGHT_W-1:0] weight_r [TOPICS];
  logic [TOTAL_W-1:0]  total_r, cum_r, thr_r;
  logic [TOTAL_W-RAND_W+RAND_W-1:0] p_hi_r;
  logic [2*RAND_W-1:0] p_lo_r;
  logic [COUNT_W-1:0]  tsum_r [TOPICS];

  // memories
  logic [COUNT_W-1:0]  doc_mem  [DOC_DEPTH];
  logic [COUNT_W-1:0]  word_mem [WORD_DEPTH];
  logic [TOPIC_W-1:0]  tok_mem  [TOK_DEPTH];
  logic [COUNT_W-1:0]  doc_q, word_q;
  logic [TOPIC_W-1:0]  tok_q;
  logic [WORD_AW-1:0]  clr_r;

  // output register
  logic                out_valid_r;
  logic [TOPIC_W-1:0]  out_topic_r;
  logic                out_changed_r;

  // divider
  logic                div_start, div_done;
  logic [NUM_W-1:0]    div_num, div_quo;
  logic [DEN_W-1:0]    div_den, div_rem;

  logic [TOPIC_W-1:0]  z_rd, z_wr;
  logic [DOC_AW-1:0]   doc_raddr, doc_waddr;
  logic [WORD_AW-1:0]  word_raddr, word_waddr;
  logic                mem_we;
  logic [COUNT_W-1:0]  doc_wdata, word_wdata;
  logic [KCOUNT_W-1:0] k_clamp;
  logic [OPND_W-1:0]   opa, opb;
  logic [WEIGHT_W-1:0] w_new;
  logic [TOTAL_W-1:0]  cum_nxt;
  logic [TOTAL_W:0]    thr_sum;
  logic                is_inc;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r  <= CFG_W'(65536);
      beta_r   <= CFG_W'(6554);
      topics_r <= KCOUNT_W'(16);
      vocab_r  <= VOCAB_W'(1024);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ALPHA: alpha_r  <= cfg_wdata;
        REG_BETA:  beta_r   <= cfg_wdata;
        REG_TOPIC: topics_r <= cfg_wdata[KCOUNT_W-1:0];
        REG_VOCAB: vocab_r  <= cfg_wdata[VOCAB_W-1:0];
        default:   ;
      endcase
    end
  end

  // active topic count, clamped to 1..TOPICS
  always_comb begin
    if (topics_r == '0) k_clamp = KCOUNT_W'(1);
    else if (topics_r > KCOUNT_W'(TOPICS)) k_clamp = KCOUNT_W'(TOPICS);
    else k_clamp = topics_r;
  end

  // count table addressing
  always_comb begin
    case (cmd.op)
      OP_OLD:  z_rd = tok_q;
      OP_W_RD: z_rd = z_cnt_r;
      default: z_rd = z_new_r;
    endcase
  end
  assign is_inc     = (cmd.op == OP_INC);
  assign z_wr       = is_inc ? z_new_r : z_old_r;
  assign doc_raddr  = {doc_r, z_rd};
  assign word_raddr = {word_r, z_rd};
  assign mem_we     = (cmd.op == OP_CLEAR) || (cmd.op == OP_DEC) || is_inc;

  always_comb begin
    doc_waddr  = {doc_r, z_wr};
    word_waddr = {word_r, z_wr};
    doc_wdata  = '0;
    word_wdata = '0;
    if (cmd.op == OP_CLEAR) begin
      doc_waddr  = clr_r[DOC_AW-1:0];
      word_waddr = clr_r;
    end else if (is_inc) begin
      doc_wdata  = (doc_q == COUNT_MAX) ? doc_q : doc_q + 1'b1;
      word_wdata = (word_q == COUNT_MAX) ? word_q : word_q + 1'b1;
    end else begin
      doc_wdata  = (doc_q == '0) ? doc_q : doc_q - 1'b1;
      word_wdata = (word_q == '0) ? word_q : word_q - 1'b1;
    end
  end

  // memories, registered reads
  always_ff @(posedge clk) begin
    doc_q  <= doc_mem[doc_raddr];
    word_q <= word_mem[word_raddr];
    tok_q  <= tok_mem[tok_r];
    if (mem_we) begin
      doc_mem[doc_waddr]   <= doc_wdata;
      word_mem[word_waddr] <= word_wdata;
    end
    if (is_inc) tok_mem[tok_r] <= z_new_r;
  end

  // per-topic totals
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TOPICS; i++) tsum_r[i] <= '0;
    end else if (cmd.op == OP_DEC) begin
      if (tsum_r[z_old_r] != '0) tsum_r[z_old_r] <= tsum_r[z_old_r] - 1'b1;
    end else if (is_inc) begin
      if (tsum_r[z_new_r] != COUNT_MAX) tsum_r[z_new_r] <= tsum_r[z_new_r] + 1'b1;
    end
  end

  // weight operands
  assign opa = {1'b0, doc_q, {QFRAC{1'b0}}} + OPND_W'(alpha_r);
  assign opb = {1'b0, word_q, {QFRAC{1'b0}}} + OPND_W'(beta_r);

  // quotient, saturated; zero denominator special-cased
  always_comb begin
    if (den_r == '0) w_new = (num_r != '0) ? WEIGHT_MAX : '0;
    else if (div_quo[NUM_W-1:WEIGHT_W] != '0) w_new = WEIGHT_MAX;
    else w_new = div_quo[WEIGHT_W-1:0];
  end

  assign cum_nxt = cum_r + TOTAL_W'(weight_r[z_cnt_r]);
  assign thr_sum = (TOTAL_W+1)'(p_hi_r) + (TOTAL_W+1)'(p_lo_r[2*RAND_W-1:RAND_W]);

  // divider operand select
  assign div_start = (cmd.op == OP_MOD_START) || (cmd.op == OP_DIV_START);
  assign div_num   = (cmd.op == OP_MOD_START) ? NUM_W'(rnd_r) : num_r;
  assign div_den   = (cmd.op == OP_MOD_START) ? DEN_W'(k_clamp) : den_r;

  lgts_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo),
    .rem   (div_rem)
  );

  // clearing pass counter
  always_ff @(posedge clk) begin
    if (!rst_n) clr_r <= '0;
    else if (cmd.op == OP_CLEAR) clr_r <= clr_r + 1'b1;
  end

  // token datapath registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        mode_r  <= in_mode;
        tok_r   <= in_token_index;
        doc_r   <= in_doc_id;
        word_r  <= in_word_id;
        rnd_r   <= in_rand_value;
        km1_r   <= TOPIC_W'(k_clamp - 1'b1);
        vb_r    <= vocab_r * beta_r;
        total_r <= '0;
        z_cnt_r <= '0;
      end
      OP_MOD_STORE: begin
        z_new_r   <= div_rem[TOPIC_W-1:0];
        changed_r <= 1'b1;
      end
      OP_OLD: z_old_r <= tok_q;
      OP_W_MUL: begin
        num_r <= opa * opb;
        den_r <= DEN_W'({tsum_r[z_cnt_r], {QFRAC{1'b0}}}) + DEN_W'(vb_r);
      end
      OP_W_STORE: begin
        weight_r[z_cnt_r] <= w_new;
        total_r <= total_r + TOTAL_W'(w_new);
        z_cnt_r <= z_cnt_r + 1'b1;
      end
      OP_THR1: begin
        p_hi_r <= total_r[TOTAL_W-1:RAND_W] * rnd_r;
        p_lo_r <= total_r[RAND_W-1:0] * rnd_r;
      end
      OP_THR2: begin
        thr_r   <= thr_sum[TOTAL_W-1:0];
        cum_r   <= '0;
        z_cnt_r <= '0;
      end
      OP_SEARCH: begin
        cum_r   <= cum_nxt;
        z_cnt_r <= z_cnt_r + 1'b1;
        if (st.search_hit) begin
          z_new_r   <= z_cnt_r;
          changed_r <= (z_cnt_r != z_old_r);
        end
      end
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.op == OP_OUT) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (cmd.op == OP_OUT) begin
      out_topic_r   <= z_new_r;
      out_changed_r <= changed_r;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_topic   = out_topic_r;
  assign out_changed = out_changed_r;

  // status to controller
  assign st.clear_last = (clr_r == {WORD_AW{1'b1}});
  assign st.mode       = mode_r;
  assign st.div_done   = div_done;
  assign st.last_topic = (z_cnt_r == km1_r);
  assign st.search_hit = (cum_nxt >= thr_r) || (z_cnt_r == km1_r);
  assign st.out_busy   = out_valid_r && !out_ready;

endmodule

@@ hw/rtl/lgts_checker.sv @@
`timescale 1ns / 1ps
module lgts_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [lgts_pkg::TOPIC_W-1:0] out_topic,
  input logic                         out_changed
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_topic) && $stable(out_changed))
    else $error("result changed while stalled");

  // reset empties the result register and starts the clearing pass
  a_rst_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_rst_in: assert property (@(posedge clk) !rst_n |=> !in_ready)
    else $error("input ready during clearing pass");

  // one token at a time
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second transfer while token in work");

endmodule

bind lda_gibbs_topic_sampler lgts_checker u_lgts_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .out_topic   (out_topic),
  .out_changed (out_changed)
);

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
module tb_top;
  import lgts_pkg::*;

  typedef struct packed {
    bit        mode;
    bit [11:0] tok;
    bit [7:0]  doc;
    bit [9:0]  word;
    bit [30:0] rnd;
  } token_t;

  typedef struct packed {
    bit [3:0] topic;
    bit       changed;
  } draw_t;

  localparam longint unsigned WMAX = (64'd1 << 48) - 1;
  localparam int CYCLE_LIMIT = 8000000;

  // Mirror of the sampler: counts, token topics and priors
  class topic_scoreboard;
    bit [3:0]  tok_topic[4096];
    bit [12:0] doc_cnt[4096];
    bit [12:0] word_cnt[16384];
    bit [12:0] tot_cnt[16];
    bit [23:0] alpha, beta;
    bit [4:0]  ktopics;
    bit [10:0] vocab;
    draw_t     draws_q[$];
    int        errors, checked;

    function new();
      foreach (doc_cnt[i]) doc_cnt[i] = 0;
      foreach (word_cnt[i]) word_cnt[i] = 0;
      foreach (tot_cnt[i]) tot_cnt[i] = 0;
      foreach (tok_topic[i]) tok_topic[i] = 0;
      alpha = 24'd65536; beta = 24'd6554; ktopics = 5'd16; vocab = 11'd1024;
      errors = 0; checked = 0;
    endfunction

    function void set_reg(lgts_reg_t idx, bit [23:0] v);
      case (idx)
        REG_ALPHA: alpha = v;
        REG_BETA:  beta = v;
        REG_TOPIC: ktopics = v[4:0];
        REG_VOCAB: vocab = v[10:0];
        default:   ;
      endcase
    endfunction

    function longint unsigned weight(longint unsigned ndz, longint unsigned nwz,
                                     longint unsigned nz);
      longint unsigned a, b, num, den, q;
      a = (ndz << 16) + alpha;
      b = (nwz << 16) + beta;
      num = a * b;
      den = (nz << 16) + longint'(vocab) * longint'(beta);
      if (den == 0) return (num != 0) ? WMAX : 0;
      q = num / den;
      return (q > WMAX) ? WMAX : q;
    endfunction

    function void bump(int d, int w, int z, bit up);
      if (up) begin
        if (doc_cnt[d*16+z] != 13'h1fff) doc_cnt[d*16+z]++;
        if (word_cnt[w*16+z] != 13'h1fff) word_cnt[w*16+z]++;
        if (tot_cnt[z] != 13'h1fff) tot_cnt[z]++;
      end else begin
        if (doc_cnt[d*16+z] != 0) doc_cnt[d*16+z]--;
        if (word_cnt[w*16+z] != 0) word_cnt[w*16+z]--;
        if (tot_cnt[z] != 0) tot_cnt[z]--;
      end
    endfunction

    // Accepted token: update mirrored tables and queue the expected draw
    function void note_input(token_t t);
      int k, z, znew, zold;
      longint unsigned wt[16];
      longint unsigned total, thr, cum;
      draw_t e;
      k = ktopics;
      if (k < 1) k = 1;
      if (k > 16) k = 16;
      if (!t.mode) begin
        znew = t.rnd % k;
        bump(t.doc, t.word, znew, 1);
        tok_topic[t.tok] = 4'(znew);
        e.topic = 4'(znew); e.changed = 1;
      end else begin
        zold = tok_topic[t.tok];
        bump(t.doc, t.word, zold, 0);
        total = 0;
        for (z = 0; z < k; z++) begin
          wt[z] = weight(doc_cnt[t.doc*16+z], word_cnt[t.word*16+z], tot_cnt[z]);
          total += wt[z];
        end
        thr = (total >> 31) * t.rnd + (((total & 64'h7fffffff) * t.rnd) >> 31);
        znew = k - 1;
        cum = 0;
        for (z = 0; z < k; z++) begin
          cum += wt[z];
          if (cum >= thr) begin
            znew = z;
            break;
          end
        end
        bump(t.doc, t.word, znew, 1);
        tok_topic[t.tok] = 4'(znew);
        e.topic = 4'(znew); e.changed = (znew != zold);
      end
      draws_q.push_back(e);
    endfunction

    task report(string msg);
      $display("MISMATCH @%0t: %s", $time, msg);
      errors++;
    endtask

    task check_result(bit [3:0] topic, bit chg);
      draw_t e;
      if (draws_q.size() == 0) begin
        report($sformatf("unexpected result topic=%0d changed=%0d", topic, chg));
      end else begin
        e = draws_q.pop_front();
        checked++;
        if (topic != e.topic)
          report($sformatf("topic %0d, expected %0d", topic, e.topic));
        if (chg != e.changed)
          report($sformatf("changed %0d, expected %0d", chg, e.changed));
      end
    endtask
  endclass

  logic clk, rst_n;
  logic in_valid, in_ready, in_mode;
  logic [TOKEN_W-1:0] in_token_index;
  logic [DOC_W-1:0] in_doc_id;
  logic [WORD_W-1:0] in_word_id;
  logic [RAND_W-1:0] in_rand_value;
  logic out_valid, out_ready, out_changed;
  logic [TOPIC_W-1:0] out_topic;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_wdata;

  lda_gibbs_topic_sampler DUT (.*);

  topic_scoreboard sb = new();
  bit assigned[4096];
  int assigned_q[$];
  int cycles = 0;
  bit hold_req = 0;
  int burst_left = 0;
  int mode1_sent = 0;

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // Run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  // Result side check
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_topic, out_changed);
  end

  // Receiver: stall pattern in segments, plus one long hold-off on request
  initial begin
    int seg, style;
    out_ready = 0;
    forever begin
      if (hold_req) begin
        out_ready <= 0;
        repeat (3000) @(posedge clk);
        hold_req = 0;
      end
      style = $urandom_range(0, 2);
      for (seg = 0; seg < 150; seg++) begin
        case (style)
          0: out_ready <= 1;
          1: out_ready <= ($urandom_range(0, 9) < 6);
          default: out_ready <= ((cycles % 11) < 4);
        endcase
        @(posedge clk);
      end
    end
  end

  task cfg_write(lgts_reg_t idx, bit [23:0] v);
    cfg_we <= 1; cfg_index <= idx; cfg_wdata <= v;
    @(posedge clk);
    sb.set_reg(idx, v);
    cfg_we <= 0;
  endtask

  // Offer one token and hold it until the transfer
  task send_token(token_t t);
    if (burst_left == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 30)) @(posedge clk);
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    in_valid <= 1;
    in_mode <= t.mode; in_token_index <= t.tok; in_doc_id <= t.doc;
    in_word_id <= t.word; in_rand_value <= t.rnd;
    do @(posedge clk); while (!in_ready);
    sb.note_input(t);
    if (t.mode) mode1_sent++;
    if (!assigned[t.tok]) begin
      assigned[t.tok] = 1;
      assigned_q.push_back(t.tok);
    end
  endtask

  task send_fields(bit m, int tk, int d, int w, bit [30:0] r);
    token_t t;
    t.mode = m; t.tok = 12'(tk); t.doc = 8'(d); t.word = 10'(w); t.rnd = r;
    send_token(t);
  endtask

  // Random token; resamples only hit tokens that already hold a topic.
  // Narrow doc/word pools build up counts so the weights differ.
  task send_random();
    token_t t;
    bit narrow;
    narrow = ($urandom_range(0, 3) != 0);
    t.mode = (assigned_q.size() > 0) && ($urandom_range(0, 9) < 7);
    t.tok = t.mode ? 12'(assigned_q[$urandom_range(0, assigned_q.size() - 1)])
                   : (narrow ? 12'($urandom_range(0, 63)) : 12'($urandom_range(0, 4095)));
    t.doc = narrow ? 8'($urandom_range(0, 3)) : 8'($urandom_range(0, 255));
    t.word = narrow ? 10'($urandom_range(0, 7)) : 10'($urandom_range(0, 1023));
    t.rnd = 31'($urandom >> 1);
    send_token(t);
  endtask

  // Drain outstanding results before touching registers
  task drain();
    in_valid <= 0;
    while (sb.draws_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task phase(bit [23:0] a, bit [23:0] b, bit [4:0] k, bit [10:0] v, int n);
    drain();
    cfg_write(REG_ALPHA, a);
    cfg_write(REG_BETA, b);
    cfg_write(REG_TOPIC, k);
    cfg_write(REG_VOCAB, v);
    repeat (n) send_random();
  endtask

  initial begin
    rst_n = 0; in_valid = 0; in_mode = 0; in_token_index = 0; in_doc_id = 0;
    in_word_id = 0; in_rand_value = 0; cfg_we = 0; cfg_index = REG_ALPHA;
    cfg_wdata = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1;

    // Directed: field extremes, both modes, reassign of an assigned token
    send_fields(0, 0, 0, 0, 31'd0);
    send_fields(0, 4095, 255, 1023, 31'h7fffffff);
    send_fields(0, 1, 0, 1023, 31'd5);
    send_fields(0, 2, 255, 0, 31'h2aaaaaaa);
    send_fields(0, 3, 0, 0, 31'h55555555);
    send_fields(1, 0, 0, 0, 31'd0);
    send_fields(1, 4095, 255, 1023, 31'h7fffffff);
    send_fields(1, 1, 0, 1023, 31'h40000000);
    send_fields(0, 1, 0, 1023, 31'd17);
    send_fields(1, 2, 255, 0, 31'h7fffffff);
    send_fields(1, 3, 0, 0, 31'd1);
    send_fields(1, 0, 0, 0, 31'h7fffffff);

    // Defaults, then zero priors (zero weights / zero total), then extremes
    phase(24'd65536, 24'd6554, 5'd16, 11'd1024, 200);
    phase(24'd0, 24'd0, 5'd4, 11'd1, 150);
    phase(24'd0, 24'd0, 5'd3, 11'd0, 60);
    phase(24'hffffff, 24'hffffff, 5'd0, 11'd2047, 100);
    phase(24'($urandom_range(0, 300000)), 24'd3000, 5'd31, 11'd0, 150);
    // Long receiver hold-off while tokens keep coming
    phase(24'd6554, 24'd655, 5'd2, 11'd1024, 20);
    hold_req = 1;
    repeat (380) send_random();
    phase(24'($urandom_range(1, 200000)), 24'($urandom_range(1, 70000)), 5'd8,
          11'($urandom_range(1, 1024)), 400);
    phase(24'd32768, 24'd100, 5'd17, 11'd1, 200);
    drain();

    $display("Run covered %0d results (%0d resamples) over %0d cycles,",
             sb.checked, mode1_sent, cycles);
    $display("topic counts 0..31 with zero, default and full-scale priors.");
    if (sb.errors == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/lgts_pkg.sv
hw/rtl/lgts_div.sv
hw/rtl/lgts_ctrl.sv
hw/rtl/lgts_dp.sv
hw/rtl/lda_gibbs_topic_sampler.sv
hw/rtl/lgts_checker.sv
tb/sv/tb_top.sv
